// ----- hw/rtl/tcs_pkg.sv -----
// ----------------------------------------------------------------------------
// tcs_pkg: shared types and constants for the tick-to-seconds converter
// Register widths, divisor width, controller states and the control bundle.
// ----------------------------------------------------------------------------
package tcs_pkg;

	localparam int MULT_W  = 32;
	localparam int FDIV_W  = 16;
	localparam int TWOS_W  = 6;
	localparam int FIVES_W = 5;
	localparam int CFG_W   = 32;
	localparam int IDX_W   = 2;
	localparam int QUOT_W  = 64;
	localparam int FRAC_W  = 32;

	// Divisor 2^63 * 5^31 * (2^32-1) stays below 2^167; one bit of margin.
	localparam int DEN_W = 168;

	typedef enum logic [IDX_W-1:0] {
		CFG_MULT  = 2'd0,
		CFG_FDIV  = 2'd1,
		CFG_TWOS  = 2'd2,
		CFG_FIVES = 2'd3
	} tcs_cfg_idx_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MULT,
		ST_SCALE,
		ST_SHIFT,
		ST_DIVIDE
	} tcs_state_t;

	typedef struct packed {
		logic load_den;   // seed divisor with the multiplier, clear dividend
		logic mul_step;   // dividend shift-and-add, one freq_divisor bit
		logic mul5;       // divisor *= 5
		logic shl2;       // divisor <<= power_of_two
		logic load_num;   // clear remainder and quotient
		logic step;       // one restoring division step
		logic int_phase;  // quotient bit belongs to the integer part
	} tcs_ctl_t;

endpackage

// ----- hw/rtl/tick_count_to_seconds_unit.sv -----
// ----------------------------------------------------------------------------
// tick_count_to_seconds_unit: tick count to seconds converter
// Steps: a shift-and-add multiply over the freq_divisor bits, the x5 steps,
//   the 2^twos shift, then the bit-serial divider, one quotient bit/cycle.
// A new start is taken only while idle, not during a conversion; it can be
//   taken in the cycle done is high.
// Reset clears the controller and the registers to 1, 1, 0, 0.
// done is a one-cycle strobe; the receiver cannot stall it.
// ----------------------------------------------------------------------------
module tick_count_to_seconds_unit
	import tcs_pkg::*;
#(
	parameter int TICK_BITS     = 64,
	parameter int FRACTION_BITS = 32
) (
	input  logic              clk,
	input  logic              arst_n,
	// configuration write port
	input  logic              cfg_write,
	input  logic [IDX_W-1:0]  cfg_index,
	input  logic [CFG_W-1:0]  cfg_data,
	// command side
	input  logic              start,
	output logic              busy,
	input  logic [63:0]       tick_count,
	// result side
	output logic              done,
	output logic [QUOT_W-1:0] whole_seconds,
	output logic [FRAC_W-1:0] second_fraction,
	output logic              overflow
);

	// Dividend is tick * freq_divisor; the divider then runs FRACTION_BITS
	// more steps past the binary point.
	localparam int NUM_W    = TICK_BITS + FDIV_W;
	localparam int STEPS    = NUM_W + FRACTION_BITS;
	localparam int STEP_W   = $clog2(STEPS);
	localparam int FRAC_EXT = (FRACTION_BITS > FRAC_W) ? FRACTION_BITS : FRAC_W;

	// configuration registers
	logic [MULT_W-1:0]  freq_multiplier_q;
	logic [FDIV_W-1:0]  freq_divisor_q;
	logic [TWOS_W-1:0]  power_of_two_q;
	logic [FIVES_W-1:0] power_of_five_q;

	// controller
	tcs_state_t          state_q, state_nxt;
	logic [FIVES_W-1:0]  five_cnt_q;
	logic [STEP_W-1:0]   step_q;
	logic                last_mul;
	logic                last_step;
	logic                done_q;
	logic [TICK_BITS-1:0] tick_q;
	tcs_ctl_t            ctl;

	// datapath results
	logic [DEN_W-1:0]         den;
	logic [FRACTION_BITS-1:0] frac;
	logic [FRAC_EXT-1:0]      frac_ext;

	// ---------------------------------------------------------------- config
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			freq_multiplier_q <= MULT_W'(1);
			freq_divisor_q    <= FDIV_W'(1);
			power_of_two_q    <= '0;
			power_of_five_q   <= '0;
		end else if (cfg_write) begin
			case (tcs_cfg_idx_t'(cfg_index))
				CFG_MULT:  freq_multiplier_q <= cfg_data[MULT_W-1:0];
				CFG_FDIV:  freq_divisor_q    <= cfg_data[FDIV_W-1:0];
				CFG_TWOS:  power_of_two_q    <= cfg_data[TWOS_W-1:0];
				CFG_FIVES: power_of_five_q   <= cfg_data[FIVES_W-1:0];
				default: ;
			endcase
		end
	end

	// ------------------------------------------------------------ controller
	// IDLE -> MULT (one freq_divisor bit per cycle) -> SCALE (one x5 per
	// cycle) -> SHIFT (apply 2^twos, clear the remainder) -> DIVIDE (one
	// quotient bit per cycle) -> IDLE.
	assign last_mul  = (step_q == STEP_W'(FDIV_W - 1));
	assign last_step = (step_q == STEP_W'(STEPS - 1));

	always_comb begin
		state_nxt = state_q;
		case (state_q)
			ST_IDLE: begin
				if (start) state_nxt = ST_MULT;
			end
			ST_MULT: begin
				if (last_mul) state_nxt = ST_SCALE;
			end
			ST_SCALE: begin
				if (five_cnt_q == power_of_five_q) state_nxt = ST_SHIFT;
			end
			ST_SHIFT: begin
				state_nxt = ST_DIVIDE;
			end
			ST_DIVIDE: begin
				if (last_step) state_nxt = ST_IDLE;
			end
			default: state_nxt = ST_IDLE;
		endcase
	end

	always_comb begin
		ctl           = '0;
		ctl.int_phase = (step_q < STEP_W'(NUM_W));
		case (state_q)
			ST_IDLE:   ctl.load_den = start;
			ST_MULT:   ctl.mul_step = 1'b1;
			ST_SCALE:  ctl.mul5     = (five_cnt_q != power_of_five_q);
			ST_SHIFT: begin
				ctl.shl2     = 1'b1;
				ctl.load_num = 1'b1;
			end
			ST_DIVIDE: ctl.step     = 1'b1;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			five_cnt_q <= '0;
			step_q     <= '0;
			done_q     <= 1'b0;
		end else begin
			state_q <= state_nxt;
			done_q  <= ctl.step && last_step;
			if (ctl.load_den) begin
				five_cnt_q <= '0;
			end else if (ctl.mul5) begin
				five_cnt_q <= five_cnt_q + FIVES_W'(1);
			end
			// shared counter: multiply bits, then division steps
			if (ctl.load_den || ctl.load_num) begin
				step_q <= '0;
			end else if (ctl.mul_step || ctl.step) begin
				step_q <= step_q + STEP_W'(1);
			end
		end
	end

	// tick is held from the start transfer until the dividend is formed
	always_ff @(posedge clk) begin
		if (ctl.load_den) tick_q <= tick_count[TICK_BITS-1:0];
	end

	// -------------------------------------------------------------- datapath
	tcs_den_gen u_den_gen (
		.clk  (clk),
		.ctl  (ctl),
		.mult (freq_multiplier_q),
		.twos (power_of_two_q),
		.den  (den)
	);

	tcs_serial_div #(
		.TICK_BITS     (TICK_BITS),
		.FRACTION_BITS (FRACTION_BITS)
	) u_serial_div (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (ctl),
		.tick   (tick_q),
		.fdiv   (freq_divisor_q),
		.den    (den),
		.quot   (whole_seconds),
		.frac   (frac),
		.ovf    (overflow)
	);

	// Result registers inside the divider hold until the remainder is
	// cleared, well after a new start, so done sees stable values.
	assign frac_ext        = FRAC_EXT'(frac);
	assign second_fraction = frac_ext[FRAC_W-1:0];
	assign done            = done_q;
	assign busy            = (state_q != ST_IDLE);

endmodule

// ----- hw/rtl/tcs_den_gen.sv -----
// ----------------------------------------------------------------------------
// tcs_den_gen: divisor builder
// Builds 2^twos * 5^fives * multiplier: one x5 per cycle, then one shift.
// ----------------------------------------------------------------------------
module tcs_den_gen
	import tcs_pkg::*;
(
	input  logic              clk,
	input  tcs_ctl_t          ctl,
	input  logic [MULT_W-1:0] mult,
	input  logic [TWOS_W-1:0] twos,
	output logic [DEN_W-1:0]  den
);

	logic [DEN_W-1:0] den_q;

	always_ff @(posedge clk) begin
		if (ctl.load_den) begin
			// zero multiplier counts as one
			den_q <= (mult == '0) ? DEN_W'(1) : DEN_W'(mult);
		end else if (ctl.mul5) begin
			den_q <= den_q + (den_q << 2);
		end else if (ctl.shl2) begin
			den_q <= den_q << twos;
		end
	end

	assign den = den_q;

endmodule

// ----- hw/rtl/tcs_serial_div.sv -----
// ----------------------------------------------------------------------------
// tcs_serial_div: bit-serial restoring divider
// Forms tick * freq_divisor by shift-and-add, one divisor bit per cycle, then
// shifts the dividend in one bit per cycle, then zeros for the fraction.
// ----------------------------------------------------------------------------
module tcs_serial_div
	import tcs_pkg::*;
#(
	parameter int TICK_BITS     = 64,
	parameter int FRACTION_BITS = 32
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  tcs_ctl_t                 ctl,
	input  logic [TICK_BITS-1:0]     tick,
	input  logic [FDIV_W-1:0]        fdiv,
	input  logic [DEN_W-1:0]         den,
	output logic [QUOT_W-1:0]        quot,
	output logic [FRACTION_BITS-1:0] frac,
	output logic                     ovf
);

	localparam int NUM_W = TICK_BITS + FDIV_W;

	logic [NUM_W-1:0]         num_q;
	logic [FDIV_W-1:0]        fdiv_q;
	logic [DEN_W-1:0]         rem_q;
	logic [QUOT_W-1:0]        quot_q;
	logic [FRACTION_BITS-1:0] frac_q;
	logic                     ovf_q;

	logic [DEN_W:0] rem_sh;
	logic [DEN_W:0] rem_diff;
	logic           qbit;

	assign rem_sh   = {rem_q, num_q[NUM_W-1]};
	assign rem_diff = rem_sh - {1'b0, den};
	assign qbit     = (rem_sh >= {1'b0, den});

	always_ff @(posedge clk) begin
		if (ctl.load_den) begin
			num_q  <= '0;
			fdiv_q <= fdiv;
		end else if (ctl.mul_step) begin
			// MSB first: acc = 2*acc + bit * tick
			num_q  <= (num_q << 1) + (fdiv_q[FDIV_W-1] ? NUM_W'(tick) : NUM_W'(0));
			fdiv_q <= fdiv_q << 1;
		end else if (ctl.load_num) begin
			rem_q  <= '0;
			quot_q <= '0;
			frac_q <= '0;
		end else if (ctl.step) begin
			num_q <= num_q << 1;
			rem_q <= qbit ? rem_diff[DEN_W-1:0] : rem_sh[DEN_W-1:0];
			if (ctl.int_phase) begin
				quot_q <= {quot_q[QUOT_W-2:0], qbit};
			end else begin
				frac_q <= {frac_q[FRACTION_BITS-2:0], qbit};
			end
		end
	end

	// sticky: a set bit falling off the top of the 64-bit quotient
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ovf_q <= 1'b0;
		end else if (ctl.load_num) begin
			ovf_q <= 1'b0;
		end else if (ctl.step && ctl.int_phase) begin
			ovf_q <= ovf_q | quot_q[QUOT_W-1];
		end
	end

	assign quot = quot_q;
	assign frac = frac_q;
	assign ovf  = ovf_q;

endmodule
